[src/assert_macros.svh]
// Assertion macros used by the checker module of the byte cipher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define SDES_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sdes checker: property failed");

// Implication, checked on every rising clock edge outside reset.
`define SDES_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdes checker: implication failed");

`endif

[src/sdes_pkg.sv]
// Package with widths, register indexes, permutation tables and S-box functions.
package sdes_pkg;

    localparam int KEY_W   = 10;
    localparam int DATA_W  = 8;
    localparam int HALF_W  = 4;
    localparam int SK_W    = 8;
    localparam int REG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_CIPHER_KEY   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd1;

    // Subkeys in the order the two rounds use them.
    typedef struct packed {
        logic [SK_W-1:0] sk_first;
        logic [SK_W-1:0] sk_second;
    } sdes_subkeys_t;

    // Permutation tables: entry i is the source bit of output bit i.
    localparam logic [3:0] P10_TAB [10] = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3,
                                            4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
    localparam logic [3:0] P8_TAB  [8]  = '{4'd5, 4'd2, 4'd6, 4'd3,
                                            4'd7, 4'd4, 4'd9, 4'd8};
    localparam logic [1:0] EP_TAB  [8]  = '{2'd3, 2'd0, 2'd1, 2'd2,
                                            2'd1, 2'd2, 2'd3, 2'd0};
    localparam logic [1:0] P4_TAB  [4]  = '{2'd1, 2'd3, 2'd2, 2'd0};
    localparam logic [2:0] IP_TAB  [8]  = '{3'd1, 3'd5, 3'd2, 3'd0,
                                            3'd3, 3'd7, 3'd4, 3'd6};
    localparam logic [2:0] IPI_TAB [8]  = '{3'd3, 3'd0, 3'd2, 3'd4,
                                            3'd6, 3'd1, 3'd7, 3'd5};

    // S-boxes indexed by row, then column.
    localparam logic [1:0] S0_TAB [4][4] = '{'{2'd1, 2'd0, 2'd3, 2'd2},
                                            '{2'd3, 2'd2, 2'd1, 2'd0},
                                            '{2'd0, 2'd2, 2'd1, 2'd0},
                                            '{2'd3, 2'd1, 2'd3, 2'd2}};
    localparam logic [1:0] S1_TAB [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                            '{2'd2, 2'd0, 2'd1, 2'd3},
                                            '{2'd3, 2'd0, 2'd1, 2'd0},
                                            '{2'd2, 2'd1, 2'd0, 2'd3}};

    function automatic logic [KEY_W-1:0] perm_p10(input logic [KEY_W-1:0] a);
        logic [KEY_W-1:0] r;
        for (int i = 0; i < KEY_W; i++) begin
            r[i] = a[P10_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [SK_W-1:0] perm_p8(input logic [KEY_W-1:0] a);
        logic [SK_W-1:0] r;
        for (int i = 0; i < SK_W; i++) begin
            r[i] = a[P8_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [SK_W-1:0] perm_ep(input logic [HALF_W-1:0] a);
        logic [SK_W-1:0] r;
        for (int i = 0; i < SK_W; i++) begin
            r[i] = a[EP_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] perm_p4(input logic [HALF_W-1:0] a);
        logic [HALF_W-1:0] r;
        for (int i = 0; i < HALF_W; i++) begin
            r[i] = a[P4_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] perm_ip(input logic [DATA_W-1:0] a);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = a[IP_TAB[i]];
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] perm_ipi(input logic [DATA_W-1:0] a);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = a[IPI_TAB[i]];
        end
        return r;
    endfunction

    // Row is the two outer bits, column the two inner bits.
    function automatic logic [1:0] sbox0(input logic [HALF_W-1:0] x);
        return S0_TAB[{x[3], x[0]}][x[2:1]];
    endfunction

    function automatic logic [1:0] sbox1(input logic [HALF_W-1:0] x);
        return S1_TAB[{x[3], x[0]}][x[2:1]];
    endfunction

    // Rotate a five-bit key half left by one.
    function automatic logic [4:0] rot5(input logic [4:0] x);
        return {x[3:0], x[4]};
    endfunction

endpackage

[src/sdes_key_sched.sv]
// Configuration registers and the key schedule that derives both round subkeys.
module sdes_key_sched (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [sdes_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [sdes_pkg::KEY_W-1:0]          wr_data,
    output sdes_pkg::sdes_subkeys_t             subkeys
);
    import sdes_pkg::*;

    logic [KEY_W-1:0] cipher_key_reg;
    logic [KEY_W-1:0] cipher_key_next;
    logic             decrypt_mode_reg;
    logic             decrypt_mode_next;
    logic [KEY_W-1:0] key_p10;
    logic [4:0]       lo_rot1;
    logic [4:0]       hi_rot1;
    logic [4:0]       lo_rot2;
    logic [4:0]       hi_rot2;
    logic [SK_W-1:0]  sk_a;
    logic [SK_W-1:0]  sk_b;

    // Register write decode; indexes beyond the list are ignored.
    always_comb
    begin
        cipher_key_next   = cipher_key_reg;
        decrypt_mode_next = decrypt_mode_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_CIPHER_KEY:   cipher_key_next   = wr_data;
                REG_DECRYPT_MODE: decrypt_mode_next = wr_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg   <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else
        begin
            cipher_key_reg   <= cipher_key_next;
            decrypt_mode_reg <= decrypt_mode_next;
        end
    end

    // P10, then one and two left rotations of each half, each followed by P8.
    always_comb
    begin
        key_p10 = perm_p10(cipher_key_reg);
        lo_rot1 = rot5(key_p10[4:0]);
        hi_rot1 = rot5(key_p10[9:5]);
        lo_rot2 = rot5(lo_rot1);
        hi_rot2 = rot5(hi_rot1);
        sk_a    = perm_p8({hi_rot1, lo_rot1});
        sk_b    = perm_p8({hi_rot2, lo_rot2});
    end

    // Decryption runs the subkeys in the opposite order.
    always_comb
    begin
        if (decrypt_mode_reg)
        begin
            subkeys.sk_first  = sk_b;
            subkeys.sk_second = sk_a;
        end
        else
        begin
            subkeys.sk_first  = sk_a;
            subkeys.sk_second = sk_b;
        end
    end

endmodule

[src/sdes_round.sv]
// Feistel round function: expansion, subkey XOR, two S-boxes and P4.
module sdes_round (
    input  logic [sdes_pkg::HALF_W-1:0] half,
    input  logic [sdes_pkg::SK_W-1:0]   subkey,
    output logic [sdes_pkg::HALF_W-1:0] f_out
);
    import sdes_pkg::*;

    logic [SK_W-1:0] mixed;
    logic [1:0]      s0_val;
    logic [1:0]      s1_val;

    // S0 takes the high nibble, S1 the low nibble.
    always_comb
    begin
        mixed  = perm_ep(half) ^ subkey;
        s0_val = sbox0(mixed[7:4]);
        s1_val = sbox1(mixed[3:0]);
        f_out  = perm_p4({s0_val, s1_val});
    end

endmodule

[src/simplified_des_byte_cipher.sv]
// Top level of the simplified DES byte cipher: input register, two rounds, result register.
//
//   channel   signals                          direction  handshake
//   request   start, busy, data_in, in_last    in         start high while busy low
//   result    done, data_out, out_last         out        done strobe for one cycle
//   config    wr_en, wr_index, wr_data         in         write when wr_en high
//
// A byte is taken every cycle; each request passes the input register, then the rounds,
// and its result and done are registered in the result register.
// The latency is set by the input register and the result register around the rounds.
// busy stays low, so the request side never waits.
// Reset clears both configuration registers and the valid and strobe flags.
// The result side cannot stall: each result's done strobe is high for exactly one cycle.
module simplified_des_byte_cipher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sdes_pkg::DATA_W-1:0]       data_in,
    input  logic                              in_last,
    output logic                              done,
    output logic [sdes_pkg::DATA_W-1:0]       data_out,
    output logic                              out_last,
    input  logic                              wr_en,
    input  logic [sdes_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [sdes_pkg::KEY_W-1:0]        wr_data
);
    import sdes_pkg::*;

    sdes_subkeys_t     subkeys;
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_last_reg;
    logic              done_reg;
    logic [DATA_W-1:0] data_out_reg;
    logic              out_last_reg;
    logic [DATA_W-1:0] ip_val;
    logic [HALF_W-1:0] f_first;
    logic [HALF_W-1:0] f_second;
    logic [HALF_W-1:0] r1;
    logic [HALF_W-1:0] l1;
    logic [DATA_W-1:0] cipher_next;
    logic              accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    sdes_key_sched u_key_sched (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .subkeys  (subkeys)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= data_in;
            in_last_reg <= in_last;
        end
    end

    // Two Feistel rounds between the input and result registers.
    assign ip_val = perm_ip(in_data_reg);

    sdes_round u_round_first (
        .half   (ip_val[3:0]),
        .subkey (subkeys.sk_first),
        .f_out  (f_first)
    );

    assign r1 = ip_val[7:4] ^ f_first;

    sdes_round u_round_second (
        .half   (r1),
        .subkey (subkeys.sk_second),
        .f_out  (f_second)
    );

    assign l1          = ip_val[3:0] ^ f_second;
    assign cipher_next = perm_ipi({l1, r1});

    // Result register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            data_out_reg <= cipher_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign done     = done_reg;
    assign data_out = data_out_reg;
    assign out_last = out_last_reg;

endmodule

[src/sdes_checker.sv]
// Port-level checker for the byte cipher and its bind to the top level.
`include "assert_macros.svh"

module sdes_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic in_last,
    input logic done,
    input logic out_last
);

    // Every request gives a result strobe through the input register and the result register.
    `SDES_ASSERT_IMP(a_req_gives_done, start && !busy, ##2 done)

    // No strobe without a matching earlier request, taken out of reset.
    `SDES_ASSERT_IMP(a_done_has_req, done, $past(start && !busy && rst_n, 2))

    // The last flag travels with its byte.
    `SDES_ASSERT_IMP(a_last_follows, done, out_last == $past(in_last, 2))

    // The request side never has to wait.
    `SDES_ASSERT(a_never_busy, !busy)

endmodule

bind simplified_des_byte_cipher sdes_checker u_sdes_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the simplified DES byte cipher: directed and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 950;

    // Register indexes past the end of the register list; writes there are dropped.
    localparam logic [sdes_pkg::REG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [sdes_pkg::REG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Bit selection maps, four bits per entry, entry 0 in the rightmost nibble.
    localparam logic [39:0] P10_SRC = {4'd5, 4'd7, 4'd8, 4'd0, 4'd9,
                                       4'd3, 4'd6, 4'd1, 4'd4, 4'd2};
    localparam logic [39:0] P8_SRC  = {8'd0, 4'd8, 4'd9, 4'd4, 4'd7,
                                       4'd3, 4'd6, 4'd2, 4'd5};
    localparam logic [39:0] EP_SRC  = {8'd0, 4'd0, 4'd3, 4'd2, 4'd1,
                                       4'd2, 4'd1, 4'd0, 4'd3};
    localparam logic [39:0] P4_SRC  = {24'd0, 4'd0, 4'd2, 4'd3, 4'd1};
    localparam logic [39:0] IP_SRC  = {8'd0, 4'd6, 4'd4, 4'd7, 4'd3,
                                       4'd0, 4'd2, 4'd5, 4'd1};
    localparam logic [39:0] IPI_SRC = {8'd0, 4'd5, 4'd7, 4'd1, 4'd6,
                                       4'd4, 4'd2, 4'd0, 4'd3};

    // Substitution boxes, two bits per entry at index {row, column}, entry 0 rightmost.
    localparam logic [31:0] S0_MAP = {2'd2, 2'd3, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd0,
                                      2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1};
    localparam logic [31:0] S1_MAP = {2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0, 2'd3,
                                      2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};

    typedef enum logic {OP_BYTE, OP_REG_WRITE} cipher_op_kind_t;

    typedef struct packed {
        cipher_op_kind_t                  kind;
        logic [sdes_pkg::DATA_W-1:0]      data;
        logic                             last;
        logic [sdes_pkg::REG_IDX_W-1:0]   index;
        logic [sdes_pkg::KEY_W-1:0]       wdata;
        logic [7:0]                       gap;
    } cipher_op_t;

    typedef struct packed {
        logic [sdes_pkg::DATA_W-1:0] data;
        logic                        last;
    } cipher_result_t;

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              start    = 1'b0;
    logic                              busy;
    logic [sdes_pkg::DATA_W-1:0]       data_in  = '0;
    logic                              in_last  = 1'b0;
    logic                              done;
    logic [sdes_pkg::DATA_W-1:0]       data_out;
    logic                              out_last;
    logic                              wr_en    = 1'b0;
    logic [sdes_pkg::REG_IDX_W-1:0]    wr_index = '0;
    logic [sdes_pkg::KEY_W-1:0]        wr_data  = '0;

    cipher_op_t     cipher_ops_q[$];
    cipher_result_t cipher_results_q[$];

    // Shadow copies of the configuration registers.
    logic [sdes_pkg::KEY_W-1:0] shadow_key     = '0;
    logic                       shadow_decrypt = 1'b0;

    int gap_left     = 0;
    int quiet_cycles = 0;
    bit head_armed   = 1'b0;
    int failures     = 0;
    int cycle_count  = 0;

    simplified_des_byte_cipher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .data_in  (data_in),
        .in_last  (in_last),
        .done     (done),
        .data_out (data_out),
        .out_last (out_last),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Output bit i takes source bit tab[i] for the first n bits.
    function automatic logic [9:0] pick_bits(input logic [9:0] src, input logic [39:0] tab,
                                             input int n);
        logic [9:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
        begin
            r[i] = src[tab[4*i +: 4]];
        end
        return r;
    endfunction

    function automatic logic [4:0] rotl5(input logic [4:0] x);
        return {x[3:0], x[4]};
    endfunction

    // Row from the two outer bits, column from the two inner bits.
    function automatic logic [1:0] sbox_pick(input logic [31:0] map, input logic [3:0] x);
        logic [3:0] idx;
        idx = {x[3], x[0], x[2:1]};
        return map[2*idx +: 2];
    endfunction

    // One round function: expand, mix in the subkey, substitute, permute.
    function automatic logic [3:0] feistel_mix(input logic [3:0] half, input logic [7:0] sk);
        logic [9:0] t;
        logic [7:0] e;
        logic [3:0] s;
        t = pick_bits({6'd0, half}, EP_SRC, 8);
        e = t[7:0] ^ sk;
        s = {sbox_pick(S0_MAP, e[7:4]), sbox_pick(S1_MAP, e[3:0])};
        t = pick_bits({6'd0, s}, P4_SRC, 4);
        return t[3:0];
    endfunction

    // Expected cipher output for one byte under the given key and mode.
    function automatic cipher_result_t sdes_cipher_byte(input logic [9:0] key,
                                                        input logic decrypt,
                                                        input logic [7:0] data,
                                                        input logic last);
        logic [9:0] k;
        logic [9:0] t;
        logic [4:0] lo5;
        logic [4:0] hi5;
        logic [7:0] sk_a;
        logic [7:0] sk_b;
        logic [7:0] sk_tmp;
        logic [3:0] l0;
        logic [3:0] r0;
        logic [3:0] l1;
        logic [3:0] r1;
        cipher_result_t res;
        k   = pick_bits(key, P10_SRC, 10);
        lo5 = rotl5(k[4:0]);
        hi5 = rotl5(k[9:5]);
        t   = pick_bits({hi5, lo5}, P8_SRC, 8);
        sk_a = t[7:0];
        lo5 = rotl5(lo5);
        hi5 = rotl5(hi5);
        t   = pick_bits({hi5, lo5}, P8_SRC, 8);
        sk_b = t[7:0];
        if (decrypt)
        begin
            sk_tmp = sk_a;
            sk_a   = sk_b;
            sk_b   = sk_tmp;
        end
        t  = pick_bits({2'b00, data}, IP_SRC, 8);
        l0 = t[7:4];
        r0 = t[3:0];
        r1 = l0 ^ feistel_mix(r0, sk_a);
        l1 = r0 ^ feistel_mix(r1, sk_b);
        t  = pick_bits({2'b00, l1, r1}, IPI_SRC, 8);
        res.data = t[7:0];
        res.last = last;
        return res;
    endfunction

    function automatic void queue_byte(input logic [7:0] data, input logic last, input int gap);
        cipher_op_t op;
        op = '0;
        op.kind = OP_BYTE;
        op.data = data;
        op.last = last;
        op.gap  = gap[7:0];
        cipher_ops_q.push_back(op);
    endfunction

    function automatic void queue_reg_write(input logic [1:0] index, input logic [9:0] wdata);
        cipher_op_t op;
        op = '0;
        op.kind  = OP_REG_WRITE;
        op.index = index;
        op.wdata = wdata;
        cipher_ops_q.push_back(op);
    endfunction

    // Mostly back-to-back, sometimes short pauses, now and then a long one.
    function automatic int pick_gap(input bit gappy);
        int r;
        if (!gappy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Request driver: issues bytes and register writes from the plan queue.
    always @(posedge clk)
    begin : request_driver
        cipher_op_t op;
        logic start_nxt;
        logic wr_nxt;
        if (!rst_n)
        begin
            start          <= 1'b0;
            wr_en          <= 1'b0;
            shadow_key     = '0;
            shadow_decrypt = 1'b0;
            gap_left       = 0;
            quiet_cycles   = 0;
            head_armed     = 1'b0;
        end
        else
        begin
            // A write landing at this edge applies to every later request.
            if (wr_en)
            begin
                if (wr_index == sdes_pkg::REG_CIPHER_KEY)
                    shadow_key = wr_data;
                else if (wr_index == sdes_pkg::REG_DECRYPT_MODE)
                    shadow_decrypt = wr_data[0];
            end
            if (start && !busy)
                cipher_results_q.push_back(sdes_cipher_byte(shadow_key, shadow_decrypt,
                                                            data_in, in_last));
            if (cipher_results_q.size() == 0 && !start && !wr_en)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            start_nxt = 1'b0;
            wr_nxt    = 1'b0;
            if (start && busy)
            begin
                // Request not taken yet: hold it.
                start_nxt = 1'b1;
            end
            else if (cipher_ops_q.size() != 0)
            begin
                op = cipher_ops_q[0];
                if (op.kind == OP_BYTE)
                begin
                    if (!head_armed)
                    begin
                        gap_left  += op.gap;
                        head_armed = 1'b1;
                    end
                    if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        op         = cipher_ops_q.pop_front();
                        data_in   <= op.data;
                        in_last   <= op.last;
                        start_nxt  = 1'b1;
                        head_armed = 1'b0;
                    end
                end
                else if (quiet_cycles >= DRAIN_CYCLES)
                begin
                    // Register writes only once every result has come back.
                    op        = cipher_ops_q.pop_front();
                    wr_index <= op.index;
                    wr_data  <= op.wdata;
                    wr_nxt    = 1'b1;
                    gap_left  = 2;
                end
            end
            start <= start_nxt;
            wr_en <= wr_nxt;
        end
    end

    // Result monitor: compares each strobed result with the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        cipher_result_t want;
        if (rst_n && done)
        begin
            if (cipher_results_q.size() == 0)
            begin
                $error("unexpected result: data_out %02h out_last %0b", data_out, out_last);
                failures++;
            end
            else
            begin
                want = cipher_results_q.pop_front();
                if (data_out !== want.data)
                begin
                    $error("data_out mismatch: expected %02h, actual %02h", want.data, data_out);
                    failures++;
                end
                if (out_last !== want.last)
                begin
                    $error("out_last mismatch: expected %0b, actual %0b", want.last, out_last);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus plan, reset and end of run.
    initial
    begin : stimulus
        int sent;
        int len;
        int r;
        bit gappy;
        logic [9:0] key;

        // Reset values of the registers: all-zero key, encrypt.
        queue_byte(8'h00, 1'b0, 0);
        queue_byte(8'hFF, 1'b1, 0);
        queue_byte(8'h01, 1'b0, 1);
        queue_byte(8'h80, 1'b1, 0);

        // All-ones key; decrypt set from a write with every upper bit high.
        queue_reg_write(sdes_pkg::REG_CIPHER_KEY, 10'h3FF);
        queue_reg_write(sdes_pkg::REG_DECRYPT_MODE, 10'h3FF);
        queue_byte(8'h00, 1'b0, 0);
        queue_byte(8'hFF, 1'b0, 0);
        queue_byte(8'hAA, 1'b0, 2);
        queue_byte(8'h55, 1'b0, 0);

        // Writes past the register list are dropped; upper data bits are masked,
        // and the mode flips in the middle of a message.
        queue_reg_write(REG_SPARE_2, 10'h3FF);
        queue_reg_write(REG_SPARE_3, 10'h155);
        queue_reg_write(sdes_pkg::REG_DECRYPT_MODE, 10'h3FE);
        queue_byte(8'h5A, 1'b0, 0);
        queue_byte(8'hA5, 1'b1, 0);

        // Alternating key bits in both modes.
        queue_reg_write(sdes_pkg::REG_CIPHER_KEY, 10'h2AA);
        queue_byte(8'hC3, 1'b0, 0);
        queue_byte(8'h3C, 1'b1, 0);
        queue_reg_write(sdes_pkg::REG_DECRYPT_MODE, 10'h001);
        queue_byte(8'hC3, 1'b0, 0);
        queue_byte(8'h3C, 1'b1, 0);

        // Random phases, each after a new decrypt mode write and mostly a new key write.
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 3);
            if (r == 0)
                key = 10'h000;
            else if (r == 1)
                key = 10'h3FF;
            else
                key = 10'($urandom_range(0, 1023));
            if ($urandom_range(0, 4) != 0)
                queue_reg_write(sdes_pkg::REG_CIPHER_KEY, key);
            queue_reg_write(sdes_pkg::REG_DECRYPT_MODE, 10'($urandom_range(0, 1023)));
            if ($urandom_range(0, 4) == 0)
                queue_reg_write($urandom_range(0, 1) ? REG_SPARE_3 : REG_SPARE_2,
                                10'($urandom_range(0, 1023)));
            len   = $urandom_range(10, 120);
            if (len > RANDOM_BYTES - sent)
                len = RANDOM_BYTES - sent;
            gappy = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++)
            begin
                queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                           pick_gap(gappy));
            end
            sent += len;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the plan to drain and every result to come back.
        @(posedge clk);
        while (cipher_ops_q.size() != 0 || start || cipher_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 3) @(posedge clk);

        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/sdes_pkg.sv
src/sdes_key_sched.sv
src/sdes_round.sv
src/simplified_des_byte_cipher.sv
src/sdes_checker.sv
tb/sv/testbench.sv
